[rtl/hrlp_pkg.sv]
package hrlp_pkg;

    typedef enum logic [2:0] {
        PH_METHOD,
        PH_URI_FIRST,
        PH_URI,
        PH_VERSION,
        PH_SKIP
    } phase_t;

    typedef enum logic [1:0] {
        ST_BUSY  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } line_status_t;

    localparam logic [1:0] METH_GET    = 2'd0;
    localparam logic [1:0] METH_PUT    = 2'd1;
    localparam logic [1:0] METH_POST   = 2'd2;
    localparam logic [1:0] METH_DELETE = 2'd3;

    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    localparam logic [3:0]  VERSION_LEN     = 4'd9;
    localparam logic [3:0]  PREFIX_MAX      = 4'd15;
    localparam logic [15:0] URI_COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] MAX_URI_LEN_RST = 16'd2048;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  method_prefix;
        logic [1:0]  method;
        logic [15:0] uri_count;
        logic [3:0]  version_pos;
        logic        line_bad;
    } line_state_t;

    localparam line_state_t LINE_STATE_RST = '{
        phase:         PH_METHOD,
        method_prefix: 4'd0,
        method:        METH_GET,
        uri_count:     16'd0,
        version_pos:   4'd0,
        line_bad:      1'b0
    };

    typedef struct packed {
        logic [15:0]  uri_length;
        logic [1:0]   method_code;
        line_status_t line_status;
        logic         uri_valid;
        logic [7:0]   uri_byte;
    } line_result_t;

    function automatic logic [3:0] method_len(input logic [1:0] m);
        case (m)
            METH_GET:    method_len = 4'd3;
            METH_PUT:    method_len = 4'd3;
            METH_POST:   method_len = 4'd4;
            METH_DELETE: method_len = 4'd6;
            default:     method_len = 4'd0;
        endcase
    endfunction

    // letter n of the method word, zero past its end
    function automatic logic [7:0] method_char(input logic [1:0] m, input logic [3:0] n);
        logic [47:0] word;
        word = 48'd0;
        case (m)
            METH_GET:    word = {24'd0, "TEG"};
            METH_PUT:    word = {24'd0, "TUP"};
            METH_POST:   word = {16'd0, "TSOP"};
            METH_DELETE: word = "ETELED";
            default:     word = 48'd0;
        endcase
        if (n < 4'd6) begin
            method_char = word[n[2:0]*8 +: 8];
        end else begin
            method_char = 8'd0;
        end
    endfunction

    function automatic logic [7:0] version_char(input logic [3:0] pos);
        case (pos)
            4'd0:    version_char = "H";
            4'd1:    version_char = "T";
            4'd2:    version_char = "T";
            4'd3:    version_char = "P";
            4'd4:    version_char = "/";
            4'd5:    version_char = "1";
            4'd6:    version_char = ".";
            4'd7:    version_char = "1";
            4'd8:    version_char = CH_CR;
            default: version_char = 8'd0;
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b == CH_SP) || (b == CH_TAB) || (b == CH_LF) ||
                   (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

endpackage

[rtl/hrlp_step.sv]
module hrlp_step
    import hrlp_pkg::*;
(
    input  line_state_t  st,
    input  logic [7:0]   data_byte,
    input  logic [15:0]  max_uri_len,
    output line_state_t  st_next,
    output line_result_t res
);

    logic [15:0] count_inc;
    logic        too_long;
    logic        is_upper;
    logic [1:0]  method_tmp;
    logic        uri_take;

    assign count_inc = (st.uri_count == URI_COUNT_MAX) ? st.uri_count
                                                       : st.uri_count + 16'd1;
    assign too_long  = count_inc > max_uri_len;
    assign is_upper  = (data_byte >= "A") && (data_byte <= "Z");

    // next line state
    always_comb begin
        st_next    = st;
        method_tmp = st.method;
        if (data_byte == CH_LF) begin
            st_next = LINE_STATE_RST;
        end else begin
            case (st.phase)
                PH_METHOD: begin
                    if (data_byte == CH_SP) begin
                        if (st.method_prefix != method_len(st.method)) begin
                            st_next.line_bad = 1'b1;
                        end
                        st_next.phase = PH_URI_FIRST;
                    end else if (!is_upper) begin
                        st_next.line_bad = 1'b1;
                        st_next.phase    = PH_SKIP;
                    end else begin
                        if (st.method_prefix == 4'd0) begin
                            case (data_byte)
                                "G":     method_tmp = METH_GET;
                                "P":     method_tmp = METH_PUT;
                                "D":     method_tmp = METH_DELETE;
                                default: st_next.line_bad = 1'b1;
                            endcase
                        end else if (st.method_prefix == 4'd1 && st.method == METH_PUT &&
                                     data_byte == "O") begin
                            method_tmp = METH_POST;
                        end
                        if (st.method_prefix >= method_len(method_tmp) ||
                            method_char(method_tmp, st.method_prefix) != data_byte) begin
                            st_next.line_bad = 1'b1;
                        end
                        st_next.method = method_tmp;
                        if (st.method_prefix < PREFIX_MAX) begin
                            st_next.method_prefix = st.method_prefix + 4'd1;
                        end
                    end
                end
                PH_URI_FIRST: begin
                    if (data_byte == CH_SLASH) begin
                        st_next.uri_count = count_inc;
                        if (too_long) begin
                            st_next.line_bad = 1'b1;
                        end
                        st_next.phase = PH_URI;
                    end else begin
                        st_next.line_bad = 1'b1;
                        st_next.phase    = PH_SKIP;
                    end
                end
                PH_URI: begin
                    if (data_byte == CH_SP) begin
                        st_next.phase       = PH_VERSION;
                        st_next.version_pos = 4'd0;
                    end else if (is_blank(data_byte)) begin
                        st_next.line_bad = 1'b1;
                        st_next.phase    = PH_SKIP;
                    end else begin
                        st_next.uri_count = count_inc;
                        if (too_long) begin
                            st_next.line_bad = 1'b1;
                        end
                    end
                end
                PH_VERSION: begin
                    if (st.version_pos < VERSION_LEN &&
                        version_char(st.version_pos) == data_byte) begin
                        st_next.version_pos = st.version_pos + 4'd1;
                    end else begin
                        st_next.line_bad = 1'b1;
                        st_next.phase    = PH_SKIP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result for this byte
    always_comb begin
        res      = '0;
        uri_take = 1'b0;
        if (data_byte == CH_LF) begin
            if (!st.line_bad && st.phase == PH_VERSION && st.version_pos == VERSION_LEN) begin
                res.line_status = ST_DONE;
                res.method_code = st.method;
                res.uri_length  = st.uri_count;
            end else begin
                res.line_status = ST_ERROR;
            end
        end else begin
            res.line_status = ST_BUSY;
            case (st.phase)
                PH_URI_FIRST: uri_take = (data_byte == CH_SLASH);
                PH_URI:       uri_take = !is_blank(data_byte);
                default:      uri_take = 1'b0;
            endcase
        end
        res.uri_valid = uri_take;
        res.uri_byte  = uri_take ? data_byte : 8'd0;
    end

endmodule

[rtl/http_request_line_parser.sv]
// HTTP request line checker, one byte per transfer.
// s_ channel: one byte of the request line per transfer in s_tdata[7:0].
// m_ channel: exactly one result per input byte, in order. m_tuser is the
// uri_valid flag (the byte in m_tdata[7:0] belongs to the URI); m_tdata also
// carries the line status (busy, complete, error), and on completion the
// method code and URI length. The verdict comes with the first line feed,
// after which the parser is back at the start of a new line.
// cfg_wr_en/cfg_wr_data write max_uri_len (reset 2048); write only when idle.
// A byte in the input register has its result registered on m_ as it advances.
// Throughput: one byte per cycle unless m_ stalls; the per-byte check is short
// combinational logic between the input register and the output register.
// A stalled m_ side holds its result; the input register keeps taking one
// more byte, then s_tready drops until the output moves.
// Reset (aresetn low, synchronous) empties both stages, clears the line
// state and sets max_uri_len to 2048.
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // data_byte[7:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,      // uri_byte[7:0], line_status[9:8],
                                      // method_code[11:10], uri_length[27:12]
    output logic        m_tuser,      // uri_valid
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data
);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    logic         out_valid_reg, out_valid_next;
    line_result_t out_result_reg, out_result_next;
    line_state_t  state_reg, state_next;
    logic [15:0]  max_uri_len_reg, max_uri_len_next;
    line_state_t  step_state;
    line_result_t step_result;
    logic         advance;
    logic         in_xfer;

    hrlp_step u_step (
        .st          (state_reg),
        .data_byte   (in_byte_reg),
        .max_uri_len (max_uri_len_reg),
        .st_next     (step_state),
        .res         (step_result)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_xfer  = s_tvalid && s_tready;

    always_comb begin
        in_valid_next    = in_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        in_byte_next     = in_xfer ? s_tdata : in_byte_reg;
        out_valid_next   = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
        out_result_next  = advance ? step_result : out_result_reg;
        state_next       = advance ? step_state : state_reg;
        max_uri_len_next = cfg_wr_en ? cfg_wr_data : max_uri_len_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            state_reg       <= LINE_STATE_RST;
            max_uri_len_reg <= MAX_URI_LEN_RST;
        end else begin
            in_valid_reg    <= in_valid_next;
            out_valid_reg   <= out_valid_next;
            state_reg       <= state_next;
            max_uri_len_reg <= max_uri_len_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg    <= in_byte_next;
        out_result_reg <= out_result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.uri_valid;
    assign m_tdata  = {4'd0, out_result_reg.uri_length, out_result_reg.method_code,
                       out_result_reg.line_status, out_result_reg.uri_byte};

    // a verdict always leaves a fresh line behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && step_result.line_status != ST_BUSY |=>
            state_reg.phase == PH_METHOD && state_reg.uri_count == 16'd0 &&
            !state_reg.line_bad)
        else $error("line state not cleared after verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.phase == PH_SKIP |-> state_reg.line_bad)
        else $error("skipping a line that is not marked bad");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> out_result_reg.line_status == ST_BUSY)
        else $error("uri byte carries a verdict");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !advance && !cfg_wr_en |=> $stable(state_reg))
        else $error("line state moved without a byte");

endmodule
